@@ rtl/rmst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

    localparam int OP_W    = 1;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;

    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    typedef logic [2:0] step_t;
    typedef logic [2:0] cond_t;
    typedef logic [1:0] wsel_t;
    typedef logic [1:0] rsel_t;

    localparam step_t ST_CLR   = 3'd0;
    localparam step_t ST_IDLE  = 3'd1;
    localparam step_t ST_WLEAF = 3'd2;
    localparam step_t ST_WUP   = 3'd3;
    localparam step_t ST_QLOOP = 3'd4;
    localparam step_t ST_OUT   = 3'd5;

    localparam cond_t JC_ALWAYS   = 3'd0;
    localparam cond_t JC_CLR_LAST = 3'd1;
    localparam cond_t JC_DISPATCH = 3'd2;
    localparam cond_t JC_AT_ROOT  = 3'd3;
    localparam cond_t JC_Q_DONE   = 3'd4;
    localparam cond_t JC_OUT_FREE = 3'd5;

    localparam wsel_t WS_NONE = 2'd0;
    localparam wsel_t WS_CLR  = 2'd1;
    localparam wsel_t WS_LEAF = 2'd2;
    localparam wsel_t WS_UP   = 2'd3;

    localparam rsel_t RS_CMD   = 2'd0;
    localparam rsel_t RS_SIB   = 2'd1;
    localparam rsel_t RS_PSIB  = 2'd2;
    localparam rsel_t RS_QNEXT = 2'd3;

    typedef struct packed {
        logic  accept;
        wsel_t wsel;
        rsel_t rsel;
        logic  qstep;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctl_t;

    function automatic ctl_t rom_word(input step_t step);
        ctl_t w;
        w = '{accept: 1'b0, wsel: WS_NONE, rsel: RS_CMD, qstep: 1'b0, emit: 1'b0,
              cond: JC_ALWAYS, target: ST_IDLE};
        unique case (step)
            ST_CLR:
            begin
                w.wsel   = WS_CLR;
                w.cond   = JC_CLR_LAST;
                w.target = ST_IDLE;
            end
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.rsel   = RS_CMD;
                w.cond   = JC_DISPATCH;
                w.target = ST_IDLE;
            end
            ST_WLEAF:
            begin
                w.wsel   = WS_LEAF;
                w.rsel   = RS_SIB;
                w.cond   = JC_ALWAYS;
                w.target = ST_WUP;
            end
            ST_WUP:
            begin
                w.wsel   = WS_UP;
                w.rsel   = RS_PSIB;
                w.cond   = JC_AT_ROOT;
                w.target = ST_IDLE;
            end
            ST_QLOOP:
            begin
                w.qstep  = 1'b1;
                w.rsel   = RS_QNEXT;
                w.cond   = JC_Q_DONE;
                w.target = ST_OUT;
            end
            ST_OUT:
            begin
                w.emit   = 1'b1;
                w.cond   = JC_OUT_FREE;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rmst_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rmst_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [rmst_pkg::OP_W-1:0]    op;
    logic [rmst_pkg::INDEX_W-1:0] first_index;
    logic [rmst_pkg::INDEX_W-1:0] last_index;
    logic [rmst_pkg::DATA_W-1:0]  value;

    modport source (output valid, output op, output first_index, output last_index,
                    output value, input ready);
    modport sink   (input valid, input op, input first_index, input last_index,
                    input value, output ready);
endinterface

interface rmst_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rmst_pkg::DATA_W-1:0] max_value;

    modport source (output valid, output max_value, input ready);
    modport sink   (input valid, input max_value, output ready);
endinterface

`default_nettype wire

@@ rtl/range_max_segment_tree.sv @@
// Range-maximum segment tree with point writes. A command beat with op = write stores value
// (cut or zero-extended to VALUE_WIDTH) at leaf first_index and recomputes all ancestors; it
// gives no response. A command beat with op = query returns one response beat holding the
// maximum over leaves first_index..last_index (last_index clamped to LEAVES-1), or zero when
// the span is empty. Writes to leaves at or beyond LEAVES are dropped. The tree lives in one
// memory of 2*B entries (B = LEAVES rounded up to a power of two) with one write port and two
// registered read ports, driven by a small microcoded sequencer. After reset a clearing pass
// zeroes all 2*B entries of the memory before the first command is taken. One tree level is
// handled per cycle. A finished response waits in an output register while the next command
// is accepted.
`timescale 1ns / 1ps
`default_nettype none

module range_max_segment_tree #(
    parameter int LEAVES      = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    rmst_cmd_if.sink   cmd,
    rmst_rsp_if.source rsp
);

    localparam int LW    = $clog2(LEAVES);
    localparam int NW    = LW + 1;
    localparam int IW    = NW + 1;
    localparam int DEPTH = 1 << NW;
    localparam int BASE  = 1 << LW;
    localparam int CW    = ((NW > rmst_pkg::INDEX_W) ? NW : rmst_pkg::INDEX_W) + 1;

    localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
    localparam logic [IW-1:0] BASE_I   = IW'(BASE);
    localparam logic [NW-1:0] BASE_N   = NW'(BASE);

    logic [VALUE_WIDTH-1:0] mem [0:DEPTH-1];

    rmst_pkg::step_t step_reg, step_next;
    rmst_pkg::ctl_t  ctl;

    logic [NW-1:0]          clr_reg, clr_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [IW-1:0]          l_reg, l_next;
    logic [IW-1:0]          r_reg, r_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [rmst_pkg::DATA_W-1:0] max_value_reg, max_value_next;

    logic                   accepted;
    logic                   out_free;
    logic [CW-1:0]          first_c, last_c, hi_c;
    logic                   write_ok, q_empty;
    logic [IW-1:0]          l0, r0;
    logic [NW-1:0]          parent;
    logic [VALUE_WIDTH-1:0] up_max;
    logic [IW-1:0]          l_step, r_step;
    logic [VALUE_WIDTH-1:0] acc_a, acc_b;
    logic                   q_done;
    logic [NW-1:0]          raddr_a, raddr_b;
    logic                   we;
    logic [NW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   jump;
    rmst_pkg::step_t        dispatch_tgt;

    assign ctl       = rmst_pkg::rom_word(step_reg);
    assign cmd.ready = ctl.accept;
    assign accepted  = cmd.valid && ctl.accept;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.max_value = max_value_reg;

    // command decode
    assign first_c  = CW'(cmd.first_index);
    assign last_c   = CW'(cmd.last_index);
    assign hi_c     = (last_c >= LEAVES_C) ? (LEAVES_C - CW'(1)) : last_c;
    assign write_ok = first_c < LEAVES_C;
    assign q_empty  = (first_c >= LEAVES_C) || (first_c > hi_c);
    assign l0       = BASE_I + IW'(first_c);
    assign r0       = BASE_I + IW'(hi_c) + IW'(1);

    // update walk
    assign parent = {1'b0, n_reg[NW-1:1]};
    assign up_max = (rd_a_reg > cur_reg) ? rd_a_reg : cur_reg;

    // query walk, half-open span [l, r)
    assign l_step = (l_reg + IW'(l_reg[0])) >> 1;
    assign r_step = r_reg >> 1;
    assign acc_a  = (l_reg[0] && (rd_a_reg > acc_reg)) ? rd_a_reg : acc_reg;
    assign acc_b  = (r_reg[0] && (rd_b_reg > acc_a)) ? rd_b_reg : acc_a;
    assign q_done = !(l_step < r_step);

    always_comb
    begin
        unique case (ctl.rsel)
            rmst_pkg::RS_CMD:
            begin
                raddr_a = NW'(l0);
                raddr_b = NW'(r0 - IW'(1));
            end
            rmst_pkg::RS_SIB:
            begin
                raddr_a = n_reg ^ NW'(1);
                raddr_b = n_reg;
            end
            rmst_pkg::RS_PSIB:
            begin
                raddr_a = parent ^ NW'(1);
                raddr_b = parent;
            end
            rmst_pkg::RS_QNEXT:
            begin
                raddr_a = NW'(l_step);
                raddr_b = NW'(r_step - IW'(1));
            end
            default:
            begin
                raddr_a = '0;
                raddr_b = '0;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = n_reg;
        wdata = cur_reg;
        unique case (ctl.wsel)
            rmst_pkg::WS_NONE:
            begin
                we = 1'b0;
            end
            rmst_pkg::WS_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            rmst_pkg::WS_LEAF:
            begin
                we    = 1'b1;
                waddr = n_reg;
                wdata = cur_reg;
            end
            rmst_pkg::WS_UP:
            begin
                we    = 1'b1;
                waddr = parent;
                wdata = up_max;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    // sequencer
    always_comb
    begin
        priority if (cmd.op == rmst_pkg::OP_WRITE)
        begin
            dispatch_tgt = write_ok ? rmst_pkg::ST_WLEAF : rmst_pkg::ST_IDLE;
        end
        else
        begin
            dispatch_tgt = q_empty ? rmst_pkg::ST_OUT : rmst_pkg::ST_QLOOP;
        end
    end

    always_comb
    begin
        unique case (ctl.cond)
            rmst_pkg::JC_ALWAYS:   jump = 1'b1;
            rmst_pkg::JC_CLR_LAST: jump = &clr_reg;
            rmst_pkg::JC_DISPATCH: jump = accepted;
            rmst_pkg::JC_AT_ROOT:  jump = (parent == NW'(1));
            rmst_pkg::JC_Q_DONE:   jump = q_done;
            rmst_pkg::JC_OUT_FREE: jump = out_free;
            default:               jump = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (jump)
        begin
            step_next = (ctl.cond == rmst_pkg::JC_DISPATCH) ? dispatch_tgt : ctl.target;
        end
    end

    // datapath registers
    always_comb
    begin
        clr_next       = clr_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        max_value_next = max_value_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctl.wsel == rmst_pkg::WS_CLR)
        begin
            clr_next = clr_reg + NW'(1);
        end

        if (accepted)
        begin
            n_next   = BASE_N + NW'(first_c);
            cur_next = VALUE_WIDTH'(cmd.value);
            l_next   = l0;
            r_next   = r0;
            acc_next = '0;
        end

        if (ctl.wsel == rmst_pkg::WS_UP)
        begin
            n_next   = parent;
            cur_next = up_max;
        end

        if (ctl.qstep)
        begin
            l_next   = l_step;
            r_next   = r_step;
            acc_next = acc_b;
        end

        if (ctl.emit && out_free)
        begin
            out_valid_next = 1'b1;
            max_value_next = rmst_pkg::DATA_W'(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= rmst_pkg::ST_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        cur_reg       <= cur_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        max_value_reg <= max_value_next;
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int LEAF_COUNT  = 1024;
    localparam int RANDOM_CMDS = 1150;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [rmst_pkg::OP_W-1:0]    op;
        logic [rmst_pkg::INDEX_W-1:0] first_index;
        logic [rmst_pkg::INDEX_W-1:0] last_index;
        logic [rmst_pkg::DATA_W-1:0]  value;
        bit                           drain;
    } cmd_beat_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    logic clk;
    logic rst_n = 1'b0;

    rmst_cmd_if cmd_bus ();
    rmst_rsp_if rsp_bus ();

    range_max_segment_tree u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    logic [rmst_pkg::DATA_W-1:0] leaf_value [LEAF_COUNT];
    logic [rmst_pkg::DATA_W-1:0] expected_max [$];
    cmd_beat_t                   beats_to_send [$];
    cmd_beat_t                   next_beat;

    int  total_beats;
    int  beats_accepted;
    int  queries_sent;
    int  responses_got;
    int  mismatches;
    int  burst_left;
    int  gap_left;
    int  rx_left;
    bit  rx_open;
    bit  hold_off;
    bit  still_busy;
    rx_mode_t rx_mode;

    task automatic report_mismatch(input string what);
        $display("mismatch @ %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [rmst_pkg::DATA_W-1:0] span_max(
        input logic [rmst_pkg::INDEX_W-1:0] lo,
        input logic [rmst_pkg::INDEX_W-1:0] hi);
        logic [rmst_pkg::DATA_W-1:0] best;
        int                          top;
        best = '0;
        top  = (int'(hi) >= LEAF_COUNT) ? LEAF_COUNT - 1 : int'(hi);
        if (int'(lo) < LEAF_COUNT)
        begin
            for (int i = int'(lo); i <= top; i++)
            begin
                if (leaf_value[i] > best)
                    best = leaf_value[i];
            end
        end
        return best;
    endfunction

    function automatic void store_leaf(input logic [rmst_pkg::INDEX_W-1:0] idx,
                                       input logic [rmst_pkg::DATA_W-1:0] val);
        if (int'(idx) < LEAF_COUNT)
            leaf_value[idx] = val;
    endfunction

    task automatic queue_cmd(input logic [rmst_pkg::OP_W-1:0] op, input int lo, input int hi,
                             input logic [rmst_pkg::DATA_W-1:0] val, input bit drain);
        cmd_beat_t b;
        b.op          = op;
        b.first_index = rmst_pkg::INDEX_W'(lo);
        b.last_index  = rmst_pkg::INDEX_W'(hi);
        b.value       = val;
        b.drain       = drain;
        beats_to_send.push_back(b);
    endtask

    function automatic int pick_index(input int hot_base, input int hot_len);
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            idx = hot_base + $urandom_range(0, hot_len - 1);
            if (idx >= LEAF_COUNT)
                idx = LEAF_COUNT - 1;
        end
        else if (roll < 80)
            idx = $urandom_range(0, LEAF_COUNT - 1);
        else if (roll < 90)
            idx = $urandom_range(0, 3);
        else
            idx = LEAF_COUNT - 1 - $urandom_range(0, 3);
        return idx;
    endfunction

    function automatic logic [rmst_pkg::DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom;
        else if (roll < 80)
            return $urandom_range(0, 255);
        else if (roll < 90)
            return '0;
        else
            return '1;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // command list: directed corners first, then random traffic
    initial
    begin
        int hot_base;
        int hot_len;
        int lo;
        int hi;
        int roll;

        queue_cmd(rmst_pkg::OP_QUERY, 0, 1023, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 0, 0, 32'h0000_0001, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 1023, 0, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 512, 0, 32'hAAAA_5555, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 0, 0, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 1023, 1023, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 0, 1023, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 1, 1022, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 5, 4, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 1023, 0, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 511, 0, 32'h5555_AAAA, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 511, 512, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 511, 511, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 0, 0, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 0, 10, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 1023, 1023, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 0, 1023, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 512, 1023, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 256, 767, 32'h0, 1'b0);
        queue_cmd(rmst_pkg::OP_WRITE, 700, 1023, 32'h0000_0007, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 512, 1023, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(rmst_pkg::OP_QUERY, 513, 1023, 32'hFFFF_FFFF, 1'b0);

        hot_base = 0;
        hot_len  = 1;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 64 == 0)
            begin
                hot_len  = $urandom_range(1, 64);
                hot_base = $urandom_range(0, LEAF_COUNT - hot_len);
            end
            lo = pick_index(hot_base, hot_len);
            if ($urandom_range(0, 99) < 40)
            begin
                queue_cmd(rmst_pkg::OP_WRITE, lo, $urandom_range(0, LEAF_COUNT - 1),
                          pick_value(), n == 0 || n == RANDOM_CMDS / 2);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    hi = lo;
                else if (roll < 55)
                    hi = lo + $urandom_range(0, 31);
                else if (roll < 75)
                    hi = $urandom_range(lo, LEAF_COUNT - 1);
                else if (roll < 85)
                begin
                    if ($urandom_range(0, 1) == 0)
                        lo = 0;
                    hi = LEAF_COUNT - 1;
                end
                else if (lo == 0)
                begin
                    lo = $urandom_range(1, LEAF_COUNT - 1);
                    hi = $urandom_range(0, lo - 1);
                end
                else
                    hi = $urandom_range(0, lo - 1);
                if (hi >= LEAF_COUNT)
                    hi = LEAF_COUNT - 1;
                queue_cmd(rmst_pkg::OP_QUERY, lo, hi, $urandom,
                          n == 0 || n == RANDOM_CMDS / 2);
            end
        end
        total_beats = beats_to_send.size();
    end

    // command driver with bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid       <= 1'b0;
            cmd_bus.op          <= rmst_pkg::OP_WRITE;
            cmd_bus.first_index <= '0;
            cmd_bus.last_index  <= '0;
            cmd_bus.value       <= '0;
            beats_accepted      <= 0;
            queries_sent        <= 0;
            burst_left          = 0;
            gap_left            = 0;
            foreach (leaf_value[i])
                leaf_value[i] = '0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                beats_accepted <= beats_accepted + 1;
                if (cmd_bus.op == rmst_pkg::OP_QUERY)
                begin
                    expected_max.push_back(span_max(cmd_bus.first_index, cmd_bus.last_index));
                    queries_sent <= queries_sent + 1;
                end
                else
                    store_leaf(cmd_bus.first_index, cmd_bus.value);
            end
            still_busy = (queries_sent + int'(cmd_bus.valid && cmd_bus.ready &&
                          cmd_bus.op == rmst_pkg::OP_QUERY)) !=
                         (responses_got + int'(rsp_bus.valid && rsp_bus.ready));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    cmd_bus.valid <= 1'b0;
                end
                else if (beats_to_send.size() != 0 && !(beats_to_send[0].drain && still_busy))
                begin
                    next_beat = beats_to_send.pop_front();
                    cmd_bus.valid       <= 1'b1;
                    cmd_bus.op          <= next_beat.op;
                    cmd_bus.first_index <= next_beat.first_index;
                    cmd_bus.last_index  <= next_beat.last_index;
                    cmd_bus.value       <= next_beat.value;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
                    end
                    else
                        burst_left--;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // response monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            responses_got <= 0;
            rx_mode       = RX_OPEN;
            rx_left       = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                responses_got <= responses_got + 1;
                if (expected_max.size() == 0)
                    report_mismatch($sformatf("unexpected beat max_value=%h", rsp_bus.max_value));
                else if (rsp_bus.max_value !== expected_max[0])
                begin
                    report_mismatch($sformatf("max_value got %h want %h",
                                              rsp_bus.max_value, expected_max[0]));
                    void'(expected_max.pop_front());
                end
                else
                    void'(expected_max.pop_front());
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 200);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_OPEN:   rx_open = 1'b1;
                RX_COIN:   rx_open = $urandom_range(0, 1);
                default:   rx_open = ($urandom_range(0, 3) == 0);
            endcase
            rsp_bus.ready <= rx_open && !hold_off;
        end
    end

    // long receiver hold-off while commands keep coming
    initial
    begin
        hold_off = 1'b0;
        @(posedge clk);
        while (responses_got < 40)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        @(posedge clk);
        while (total_beats == 0 || beats_accepted != total_beats)
            @(posedge clk);
        while (queries_sent != responses_got)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_max.size() != 0)
            report_mismatch($sformatf("%0d query beats never answered", expected_max.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
